// ----- src/depq_pkg.sv -----
// Shared constants and types for the double-ended priority queue.
`timescale 1ns / 1ps
`default_nettype none

package depq_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2
  } op_t;

  typedef struct packed {
    logic ins;
    logic del_min;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/depq_cell.sv -----
// One cell of the sorted chain: holds one value and shifts or inserts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module depq_cell
  import depq_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [VAL_W-1:0] ins_val,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic             left_gt,
  input  wire logic [VAL_W-1:0] right_val,
  input  wire logic             occ,
  input  wire logic             at_end,
  output logic      [VAL_W-1:0] val,
  output logic                  gt
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  assign gt  = occ && ($signed(val_r) > $signed(ins_val));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (gt || at_end) begin
        val_nxt = left_gt ? left_val : ins_val;
      end
    end else if (cmd.del_min && occ) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ----- src/depq_chain.sv -----
// Row of sorted cells with the selection of the least and greatest stored values.
`timescale 1ns / 1ps
`default_nettype none

module depq_chain
  import depq_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [VAL_W-1:0] ins_val,
  input  wire logic [CNT_W-1:0] count,
  output logic      [VAL_W-1:0] max_val,
  output logic      [VAL_W-1:0] min_val
);

  logic [VAL_W-1:0] vals [CAPACITY];
  logic             gts  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic             left_gt;
    logic [VAL_W-1:0] right_val;
    logic             occ;
    logic             at_end;

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_inner_left
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_right
      assign right_val = vals[i+1];
    end

    assign occ    = count > CNT_W'(i);
    assign at_end = count == CNT_W'(i);

    depq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .ins_val   (ins_val),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .occ       (occ),
      .at_end    (at_end),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  always_comb begin
    max_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      max_val = max_val | (vals[k] & {VAL_W{count == CNT_W'(k + 1)}});
    end
  end

  assign min_val = vals[0];

endmodule

`default_nettype wire

// ----- src/double_ended_priority_queue_top.sv -----
// Top level of the double-ended priority queue with handshake, count and result register.
// An accepted item waits as pending until the result register captures it from the chain.
// Throughput: one item per cycle while out_stall is low; every cell of the sorted chain
// updates in the accept cycle, and the next item may already enter in the capture cycle.
// Reset clears the count and the handshake state; the cells need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_priority_queue_top
  import depq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic        [1:0]       in_opcode,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed      [VAL_W-1:0] out_largest,
  output logic signed      [VAL_W-1:0] out_smallest,
  output logic                         out_is_empty,
  output logic                         out_dropped,
  output logic             [OCC_W-1:0] out_occupancy
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r, pend_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic signed [VAL_W-1:0] largest_r, smallest_r;
  logic                    empty_r, dropped_r;
  logic [OCC_W-1:0]        occ_r;

  cell_cmd_t        cmd;
  logic             in_acc;
  logic             capture;
  logic             full;
  logic             empty;
  logic [VAL_W-1:0] max_val, min_val;

  assign full     = count_r == CNT_W'(CAPACITY);
  assign empty    = count_r == '0;
  assign capture  = pend_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_r && !capture;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (in_acc) begin
      drop_nxt = 1'b0;
      unique case (op_t'(in_opcode))
        OP_INSERT: begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEL_MAX: begin
          if (!empty) begin
            count_nxt = count_r - 1'b1;
          end
        end
        OP_DEL_MIN: begin
          if (!empty) begin
            cmd.del_min = 1'b1;
            count_nxt   = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign pend_nxt      = in_acc || (pend_r && !capture);
  assign out_valid_nxt = capture || (out_valid_r && out_stall);

  depq_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .ins_val (in_value),
    .count   (count_r),
    .max_val (max_val),
    .min_val (min_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      largest_r  <= max_val;
      smallest_r <= empty ? '0 : min_val;
      empty_r    <= empty;
      dropped_r  <= drop_r;
      occ_r      <= OCC_W'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_largest   = largest_r;
  assign out_smallest  = smallest_r;
  assign out_is_empty  = empty_r;
  assign out_dropped   = dropped_r;
  assign out_occupancy = occ_r;

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_is_empty |-> out_largest >= out_smallest)
    else $error("Result has largest below smallest.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_empty |-> out_largest == '0 && out_smallest == '0)
    else $error("Empty result carries nonzero values.");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_INSERT) && full |=> drop_r && pend_r && $stable(count_r))
    else $error("Insert into a full store was not dropped.");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_DEL_MAX || in_opcode == OP_DEL_MIN) && !empty
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("Delete did not lower the count by one.");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> count_r <= CNT_W'(CAPACITY) && (!drop_r || full))
    else $error("Count exceeds capacity or drop without a full store.");

endmodule

`default_nettype wire

// ----- tb/sv/double_ended_priority_queue_top_tb.sv -----
// Self-checking testbench for the double-ended priority queue top level.
`timescale 1ns / 1ps

module double_ended_priority_queue_top_tb;
  import depq_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEM_TARGET = 800;
  localparam int HOLD_CYCLES = 200;

  typedef enum {SEG_FILL, SEG_MIX, SEG_DRAIN} seg_kind_t;

  typedef struct {
    logic signed [VAL_W-1:0] largest;
    logic signed [VAL_W-1:0] smallest;
    logic                    is_empty;
    logic                    dropped;
    logic [OCC_W-1:0]        occupancy;
  } queue_status_t;

  class depq_scoreboard;
    logic signed [VAL_W-1:0] sorted_vals[$];
    queue_status_t pending_status[$];
    int n_errors;
    int n_checked;
    int n_inserts;
    int n_drops;
    int n_empty_deletes;
    int peak_fill;

    function void note_item(logic [1:0] op, logic signed [VAL_W-1:0] val);
      queue_status_t st;
      int pos;
      st.dropped = 1'b0;
      case (op)
        OP_INSERT: begin
          n_inserts++;
          if (sorted_vals.size() >= CAPACITY) begin
            st.dropped = 1'b1;
            n_drops++;
          end else begin
            pos = sorted_vals.size();
            while (pos > 0 && sorted_vals[pos-1] > val) pos--;
            sorted_vals.insert(pos, val);
          end
        end
        OP_DEL_MAX: begin
          if (sorted_vals.size() > 0) void'(sorted_vals.pop_back());
          else n_empty_deletes++;
        end
        OP_DEL_MIN: begin
          if (sorted_vals.size() > 0) void'(sorted_vals.pop_front());
          else n_empty_deletes++;
        end
        default: ;
      endcase
      if (sorted_vals.size() == 0) begin
        st.largest  = '0;
        st.smallest = '0;
        st.is_empty = 1'b1;
      end else begin
        st.largest  = sorted_vals[sorted_vals.size()-1];
        st.smallest = sorted_vals[0];
        st.is_empty = 1'b0;
      end
      st.occupancy = OCC_W'(sorted_vals.size());
      if (sorted_vals.size() > peak_fill) peak_fill = sorted_vals.size();
      pending_status = {pending_status, st};
    endfunction

    function void compare_field(string name, longint exp_val, longint got_val);
      if (exp_val != got_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
        n_errors++;
      end
    endfunction

    function void check_result(queue_status_t got);
      queue_status_t exp_st;
      if (pending_status.size() == 0) begin
        $error("Result arrived with no item outstanding");
        n_errors++;
        return;
      end
      exp_st = pending_status.pop_front();
      n_checked++;
      compare_field("largest", exp_st.largest, got.largest);
      compare_field("smallest", exp_st.smallest, got.smallest);
      compare_field("is_empty", exp_st.is_empty, got.is_empty);
      compare_field("dropped", exp_st.dropped, got.dropped);
      compare_field("occupancy", exp_st.occupancy, got.occupancy);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_opcode;
  logic signed [VAL_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [VAL_W-1:0] out_largest;
  logic signed [VAL_W-1:0] out_smallest;
  logic out_is_empty;
  logic out_dropped;
  logic [OCC_W-1:0] out_occupancy;

  depq_scoreboard sb = new();
  int n_sent;
  int cycle_count;
  logic quiet;

  double_ended_priority_queue_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_largest  (out_largest),
    .out_smallest (out_smallest),
    .out_is_empty (out_is_empty),
    .out_dropped  (out_dropped),
    .out_occupancy(out_occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(input logic [1:0] op, input logic signed [VAL_W-1:0] val);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, val);
    if (op != OP_NOP) n_sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_op(seg_kind_t kind, int bias_pct);
    int unsigned r;
    logic [1:0] del_op;
    r = $urandom_range(0, 99);
    del_op = $urandom_range(0, 1) ? OP_DEL_MAX : OP_DEL_MIN;
    if (r < 3 && bias_pct < 100) return OP_NOP;
    case (kind)
      SEG_FILL:  return (r < bias_pct) ? OP_INSERT : del_op;
      SEG_DRAIN: return (r < bias_pct) ? del_op : OP_INSERT;
      default:   return (r < 52) ? OP_INSERT : del_op;
    endcase
  endfunction

  task automatic run_segment(seg_kind_t kind, int len, int bias_pct);
    for (int i = 0; i < len; i++) begin
      quiet = (n_sent >= 350 && n_sent < 500);
      send_item(pick_op(kind, bias_pct), rand_value());
    end
  endtask

  // Receiver: random back-pressure plus one long hold-off once traffic is flowing.
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.n_checked >= 250) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    queue_status_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.largest   = out_largest;
      got.smallest  = out_smallest;
      got.is_empty  = out_is_empty;
      got.dropped   = out_dropped;
      got.occupancy = out_occupancy;
      sb.check_result(got);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[double_ended_priority_queue_top] ERROR");
    $finish;
  end

  initial begin
    int round;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = OP_INSERT;
    in_value  = '0;
    quiet     = 1'b0;
    n_sent    = 0;
    round     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_DEL_MAX, 32'sh1234_5678);
    send_item(OP_DEL_MIN, -5);
    send_item(OP_NOP, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 1);
    send_item(OP_NOP, -1);
    send_item(OP_INSERT, 32'sh7FFF_FFFF);
    send_item(OP_DEL_MAX, 0);
    send_item(OP_DEL_MIN, 0);
    send_item(OP_DEL_MAX, -1);
    send_item(OP_DEL_MIN, 32'sh8000_0000);
    send_item(OP_DEL_MIN, 0);
    send_item(OP_DEL_MAX, 0);
    send_item(OP_DEL_MAX, 0);
    send_item(OP_DEL_MIN, 32'sh5555_5555);
    send_item(OP_INSERT, 32'sh5555_5555);
    send_item(OP_INSERT, 32'shAAAA_AAAA);
    send_item(OP_DEL_MIN, 0);
    send_item(OP_DEL_MAX, 0);

    // Fill past capacity, churn near the top, then drain to empty and beyond.
    while (n_sent < ITEM_TARGET) begin
      run_segment(SEG_FILL, $urandom_range(70, 90), (round == 0) ? 100 : 95);
      run_segment(SEG_MIX, $urandom_range(20, 40), 0);
      run_segment(SEG_DRAIN, $urandom_range(70, 90), 95);
      round++;
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d results over %0d fill/drain rounds; peak fill %0d of %0d.",
             sb.n_checked, round, sb.peak_fill, CAPACITY);
    $display("Inserts %0d (refused when full: %0d), deletes on an empty queue %0d.",
             sb.n_inserts, sb.n_drops, sb.n_empty_deletes);
    if (sb.n_errors == 0) begin
      $display("[double_ended_priority_queue_top] OK");
    end else begin
      $display("[double_ended_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule
